>>> design/assert_macros.svh
// Assertion macros shared by the checker modules of the circle interpolator.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/scic_pkg.sv
// Package for the stepper circle interpolator: widths, quadrant codes and item types.
// Depends on nothing; imported by every module of the block.
package scic_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 14;
    // Squared radius terms at full precision, with room for sign and carries.
    localparam int SQ_WIDTH     = 2 * COORD_WIDTH + 3;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(4000);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [RADIUS_WIDTH-1:0]       t_radius;

    typedef enum logic [1:0] {
        QUAD_1,
        QUAD_2,
        QUAD_3,
        QUAD_4
    } t_quadrant;

    typedef struct packed {
        logic draw_enable;
        logic a_pending;
        logic b_pending;
    } t_in_item;

    typedef struct packed {
        logic step_a;
        logic step_b;
        logic dir_a;
        logic dir_b;
        logic motors_on;
    } t_out_item;

    typedef struct packed {
        t_coord    pos_a;
        t_coord    pos_b;
        t_quadrant quadrant;
    } t_track_state;

endpackage

>>> design/scic_step_select.sv
// Combinational step decision: quadrant directions, radial errors and the chosen step.
// Depends on scic_pkg.
module scic_step_select (
    input  scic_pkg::t_in_item     i_item,
    input  scic_pkg::t_track_state i_state,
    input  scic_pkg::t_radius      i_radius,
    output scic_pkg::t_out_item    o_result,
    output scic_pkg::t_track_state o_next_state
);
    import scic_pkg::*;

    localparam logic signed [SQ_WIDTH-1:0] ONE_SQ = SQ_WIDTH'(1);

    logic signed [COORD_WIDTH-1:0] a;
    logic signed [COORD_WIDTH-1:0] b;
    logic signed [SQ_WIDTH-1:0]    a_ext;
    logic signed [SQ_WIDTH-1:0]    b_ext;
    logic [2*COORD_WIDTH-1:0]      a_sq;
    logic [2*COORD_WIDTH-1:0]      b_sq;
    logic [2*RADIUS_WIDTH-1:0]     r_sq;
    logic signed [SQ_WIDTH-1:0]    sq_miss;
    logic signed [SQ_WIDTH-1:0]    term_a;
    logic signed [SQ_WIDTH-1:0]    term_b;
    logic [SQ_WIDTH-1:0]           err_a;
    logic [SQ_WIDTH-1:0]           err_b;
    logic [SQ_WIDTH-1:0]           err_ab;
    logic                          dir_a;
    logic                          dir_b;
    logic                          take_a;
    logic                          take_b;
    t_quadrant                     quad_next;
    t_coord                        na;
    t_coord                        nb;

    function automatic logic [SQ_WIDTH-1:0] abs_err(input logic signed [SQ_WIDTH-1:0] v);
        return v[SQ_WIDTH-1] ? SQ_WIDTH'(-v) : SQ_WIDTH'(v);
    endfunction

    assign a     = i_state.pos_a;
    assign b     = i_state.pos_b;
    assign a_ext = SQ_WIDTH'(a);
    assign b_ext = SQ_WIDTH'(b);

    // Directions of the current quadrant and the move to the next one.
    always_comb begin
        dir_a     = 1'b0;
        dir_b     = 1'b0;
        quad_next = i_state.quadrant;
        unique case (i_state.quadrant)
            QUAD_1: begin
                if (a == '0) quad_next = QUAD_2;
            end
            QUAD_2: begin
                dir_b = 1'b1;
                if (b == '0) quad_next = QUAD_3;
            end
            QUAD_3: begin
                dir_a = 1'b1;
                dir_b = 1'b1;
                if (a == '0) quad_next = QUAD_4;
            end
            QUAD_4: begin
                dir_a = 1'b1;
                if (b == '0) quad_next = QUAD_1;
            end
        endcase
    end

    // Squares of the present position and of the radius, in parallel.
    assign a_sq    = a * a;
    assign b_sq    = b * b;
    assign r_sq    = i_radius * i_radius;
    assign sq_miss = $signed(SQ_WIDTH'(a_sq) + SQ_WIDTH'(b_sq) - SQ_WIDTH'(r_sq));

    // Change of a squared coordinate for one step: (x+1)^2 - x^2 or (x-1)^2 - x^2.
    assign term_a = dir_a ? (a_ext + a_ext + ONE_SQ) : (ONE_SQ - a_ext - a_ext);
    assign term_b = dir_b ? (ONE_SQ - b_ext - b_ext) : (b_ext + b_ext + ONE_SQ);

    assign err_a  = abs_err(sq_miss + term_a);
    assign err_b  = abs_err(sq_miss + term_b);
    assign err_ab = abs_err(sq_miss + term_a + term_b);

    // Nearest candidate wins; ties go to a only, then b only.
    always_comb begin
        take_a = 1'b1;
        take_b = 1'b1;
        priority if (err_a <= err_b && err_a <= err_ab) begin
            take_b = 1'b0;
        end else if (err_b <= err_a && err_b <= err_ab) begin
            take_a = 1'b0;
        end else begin
            take_a = 1'b1;
            take_b = 1'b1;
        end
    end

    assign na = dir_a ? t_coord'(a + COORD_WIDTH'(1)) : t_coord'(a - COORD_WIDTH'(1));
    assign nb = dir_b ? t_coord'(b - COORD_WIDTH'(1)) : t_coord'(b + COORD_WIDTH'(1));

    // Result item and new tracking state for this tick.
    always_comb begin
        o_result     = '0;
        o_next_state = i_state;
        priority if (!i_item.draw_enable) begin
            o_next_state.pos_a    = t_coord'(i_radius);
            o_next_state.pos_b    = '0;
            o_next_state.quadrant = QUAD_1;
        end else if (!i_item.a_pending && !i_item.b_pending) begin
            o_result.step_a       = take_a;
            o_result.step_b       = take_b;
            o_result.dir_a        = dir_a;
            o_result.dir_b        = dir_b;
            o_result.motors_on    = 1'b1;
            o_next_state.quadrant = quad_next;
            if (take_a) o_next_state.pos_a = na;
            if (take_b) o_next_state.pos_b = nb;
        end else begin
            // A step is still pending: idle item, position and quadrant kept.
            o_next_state = i_state;
        end
    end

endmodule

>>> design/stepper_circle_interpolator_core.sv
// Top level of the stepper circle interpolator: input register, tracking state, result register.
// Depends on scic_pkg and scic_step_select.
// An accepted item passes through the input register, then the result register; throughput one item a cycle
// while the output is not stalled. A single step-decision pass lies between the input and result registers.
// Synchronous active-low reset: radius 4000, position (4000, 0), quadrant one, both stages empty.
module stepper_circle_interpolator_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  scic_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output scic_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_wr_en,
    input  scic_pkg::t_radius    i_cfg_wr_data
);
    import scic_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in_item;
    logic         r_out_valid;
    t_out_item    r_out_item;
    t_radius      r_radius;
    t_track_state r_state;
    t_track_state n_state;
    t_out_item    n_out_item;
    logic         out_free;
    logic         advance;
    logic         in_take;

    // Handshake: the item in the input register moves on when the result register frees.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_take    = i_in_valid && (!r_in_valid || advance);
    assign o_in_stall = r_in_valid && !advance;

    // Radius register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    scic_step_select u_step_select (
        .i_item       (r_in_item),
        .i_state      (r_state),
        .i_radius     (r_radius),
        .o_result     (n_out_item),
        .o_next_state (n_state)
    );

    // Tracking state advances together with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos_a    <= t_coord'(RADIUS_RESET);
            r_state.pos_b    <= '0;
            r_state.quadrant <= QUAD_1;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/scic_checker.sv
// Port-level checker for the stepper circle interpolator, bound to the top level.
// Depends on scic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scic_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input scic_pkg::t_out_item o_out_item
);
    import scic_pkg::*;

    // A stalled result item stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // With the result register empty, an offered item is never stalled.
    `ASSERT_IMPLY(a_in_free, i_clk, i_rst_n, i_in_valid && !o_out_valid, !o_in_stall)

    // A tick without a step gives an all-zero item, directions included.
    `ASSERT_IMPLY(a_idle_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.motors_on, !o_out_item.step_a && !o_out_item.step_b && !o_out_item.dir_a && !o_out_item.dir_b)

    // A step always moves at least one axis.
    `ASSERT_IMPLY(a_step_moves, i_clk, i_rst_n, o_out_valid && o_out_item.motors_on, o_out_item.step_a || o_out_item.step_b)

endmodule

bind stepper_circle_interpolator_core scic_checker u_scic_checker (.*);

>>> test/tb_stepper_circle_interpolator_core.sv
// Self-checking testbench for stepper_circle_interpolator_core: random-handshake stimulus,
// a cycle-free model of the circle stepping and an in-order result checker.
// Depends on scic_pkg and the design files of the interpolator core.
module tb_stepper_circle_interpolator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import scic_pkg::*;

    localparam int    PIPE_LATENCY = 2;
    localparam int    PHASE_COUNT  = 12;
    localparam int    PHASE_ITEMS  = 146;
    localparam int    DRAIN_LIMIT  = 20000;
    localparam time   RUN_LIMIT_NS = 20_000_000;

    // Tracks the expected position, quadrant and radius and keeps the step items still owed.
    class circle_step_tracker;
        t_coord    pos_a;
        t_coord    pos_b;
        t_quadrant quad;
        t_radius   radius;
        t_out_item expected_steps[$];
        int        mismatches;
        int        checked_count;

        function new();
            radius        = RADIUS_RESET;
            pos_a         = t_coord'(RADIUS_RESET);
            pos_b         = '0;
            quad          = QUAD_1;
            mismatches    = 0;
            checked_count = 0;
        endfunction

        function void set_radius(t_radius r);
            radius = r;
        endfunction

        function int outstanding();
            return expected_steps.size();
        endfunction

        // Distance of a candidate point's squared radius from the target, full precision.
        function longint radial_miss(longint a, longint b, longint r2);
            longint e;
            e = a * a + b * b - r2;
            return (e < 0) ? -e : e;
        endfunction

        // Works out the step item caused by one accepted tick and updates the position.
        function void note_tick(t_in_item it);
            t_out_item res;
            longint    a, b, na, nb, r2, e_a, e_b, e_ab;
            logic      da, db;
            res = '0;
            if (!it.draw_enable) begin
                pos_a = t_coord'(radius);
                pos_b = '0;
                quad  = QUAD_1;
            end else if (!(it.a_pending || it.b_pending)) begin
                a = longint'(pos_a);
                b = longint'(pos_b);
                // Directions of the present quadrant; the crossing test picks the next one.
                case (quad)
                    QUAD_1: begin
                        da = 1'b0; db = 1'b0;
                        if (a == 0) quad = QUAD_2;
                    end
                    QUAD_2: begin
                        da = 1'b0; db = 1'b1;
                        if (b == 0) quad = QUAD_3;
                    end
                    QUAD_3: begin
                        da = 1'b1; db = 1'b1;
                        if (a == 0) quad = QUAD_4;
                    end
                    default: begin
                        da = 1'b1; db = 1'b0;
                        if (b == 0) quad = QUAD_1;
                    end
                endcase
                na   = da ? a + 1 : a - 1;
                nb   = db ? b - 1 : b + 1;
                r2   = longint'(radius) * longint'(radius);
                e_a  = radial_miss(na, b, r2);
                e_b  = radial_miss(a, nb, r2);
                e_ab = radial_miss(na, nb, r2);
                // Ties go to a alone, then b alone, then both.
                if (e_a <= e_b && e_a <= e_ab) begin
                    res.step_a = 1'b1;
                end else if (e_b <= e_a && e_b <= e_ab) begin
                    res.step_b = 1'b1;
                end else begin
                    res.step_a = 1'b1;
                    res.step_b = 1'b1;
                end
                if (res.step_a) pos_a = t_coord'(na);
                if (res.step_b) pos_b = t_coord'(nb);
                res.dir_a     = da;
                res.dir_b     = db;
                res.motors_on = 1'b1;
            end
            expected_steps.push_back(res);
        endfunction

        function void check_field(string name, logic exp_v, logic act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0b, got %0b", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Compares one delivered step item with the oldest one owed.
        function void check_step(t_out_item got);
            t_out_item exp_item;
            checked_count++;
            if (expected_steps.size() == 0) begin
                $error("step item %b delivered with none owed", got);
                mismatches++;
                return;
            end
            exp_item = expected_steps.pop_front();
            check_field("step_a",    exp_item.step_a,    got.step_a);
            check_field("step_b",    exp_item.step_b,    got.step_b);
            check_field("dir_a",     exp_item.dir_a,     got.dir_a);
            check_field("dir_b",     exp_item.dir_b,     got.dir_b);
            check_field("motors_on", exp_item.motors_on, got.motors_on);
        endfunction

        function void report_leftover();
            if (expected_steps.size() != 0) begin
                $error("%0d step items never delivered", expected_steps.size());
                mismatches += expected_steps.size();
            end
        endfunction
    endclass

    logic      i_clk         = 1'b0;
    logic      i_rst_n       = 1'b0;
    logic      i_in_valid    = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item     = '0;
    logic      o_out_valid;
    logic      i_out_stall   = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_wr_en   = 1'b0;
    t_radius   i_cfg_wr_data = '0;

    circle_step_tracker tracker = new();

    stepper_circle_interpolator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offers one tick item after an optional gap and returns once it has been taken.
    task automatic send_tick(t_in_item it, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_tick(it);
    endtask

    function automatic int pick_gap(bit gapless);
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly drawing ticks with random pending flags; now and then a return to the start.
    function automatic t_in_item random_tick();
        t_in_item it;
        it.draw_enable = ($urandom_range(0, 99) >= 3);
        it.a_pending   = ($urandom_range(0, 99) < 12);
        it.b_pending   = ($urandom_range(0, 99) < 12);
        return it;
    endfunction

    // Waits until every owed item has come back or the drain limit runs out, then lets the pipeline empty.
    task automatic drain();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_radius(t_radius r);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        tracker.set_radius(r);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: checks delivered items and stalls in random runs, once for a long stretch.
    initial begin
        int hold_left;
        int go_left;
        bit pressure_done;
        hold_left     = 0;
        go_left       = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_step(o_out_item);
            if (!pressure_done && tracker.checked_count >= 400) begin
                pressure_done = 1'b1;
                hold_left     = 120;
                go_left       = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (go_left > 0) begin
                go_left--;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 1) == 0) begin
                go_left     = $urandom_range(0, 20);
                i_out_stall <= 1'b0;
            end else begin
                hold_left   = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Stimulus: reset, a directed opening at the reset radius, then random phases.
    initial begin
        t_in_item it;
        t_radius  r;
        int       p;
        int       k;
        bit       gapless;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every input combination, with and without drawing, then a run of plain steps.
        for (k = 0; k < 8; k++) begin
            it = t_in_item'(k[2:0]);
            send_tick(it, k % 2);
        end
        it = '{draw_enable: 1'b1, a_pending: 1'b0, b_pending: 1'b0};
        for (k = 0; k < 12; k++) send_tick(it, 0);
        it.draw_enable = 1'b0;
        send_tick(it, 0);
        drain();

        for (p = 0; p < PHASE_COUNT; p++) begin
            // Extremes first, then mostly small circles so that every quadrant is swept.
            case (p)
                0:       r = t_radius'(1);
                1:       r = '1;
                2:       r = '0;
                3:       r = t_radius'(2);
                4:       r = RADIUS_RESET;
                default: r = ($urandom_range(0, 99) < 80) ? t_radius'($urandom_range(1, 40))
                                                          : t_radius'($urandom_range(1, 16383));
            endcase
            write_radius(r);
            gapless = ($urandom_range(0, 2) == 0);
            // Usually restart from the start point; otherwise keep the old position.
            if ($urandom_range(0, 9) < 7) begin
                it = '{draw_enable: 1'b0, a_pending: 1'b0, b_pending: 1'b0};
                send_tick(it, 0);
            end
            for (k = 0; k < PHASE_ITEMS; k++) send_tick(random_tick(), pick_gap(gapless));
            drain();
        end

        tracker.report_leftover();
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
